FILE: sv/assert_macros.svh
// assertion macros shared by the hash engine modules
// expects clk and arst_n in the scope of each use
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition holds at every clock edge out of reset
`define ASSERT_ALWAYS(label, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond)) \
		else $error(msg);

// consequent holds in the same cycle as the antecedent
`define ASSERT_IMPLIES(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// consequent holds in the cycle after the antecedent
`define ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: sv/shae_pkg.sv
// shared types, constants and round functions of the sha-256 hash engine
// no dependencies
package shae_pkg;

	localparam int unsigned Rounds    = 64;
	localparam int unsigned HashWords = 8;
	localparam int unsigned BlockBytes = 64;
	localparam int unsigned LenBytesAt = 56;
	localparam int unsigned FillW     = 7;
	localparam int unsigned LenW      = 61;
	localparam int unsigned RoundW    = $clog2(Rounds);
	localparam int unsigned WordIdxW  = $clog2(HashWords);

	localparam logic [7:0] PadMarker = 8'h80;

	// round constants
	localparam logic [31:0] RoundK [Rounds] = '{
		32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
		32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
		32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
		32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
		32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
		32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
		32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
		32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
		32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
		32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
		32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
		32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
		32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
		32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
		32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
		32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
	};

	// initial hash value
	localparam logic [31:0] InitHash [HashWords] = '{
		32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
		32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
	};

	// payload of one request on the message side
	typedef struct packed {
		logic [7:0] data_byte;
		logic       has_byte;
		logic       end_of_message;
	} msg_t;

	// payload of one request on the digest side
	typedef struct packed {
		logic [31:0]         digest_word;
		logic [WordIdxW-1:0] word_index;
		logic                last_word;
	} dig_t;

	// source of a byte shifted into the block buffer
	typedef enum logic [1:0] {
		PUT_MSG,
		PUT_MARK,
		PUT_ZERO,
		PUT_LEN
	} put_sel_t;

	// controller to datapath
	typedef struct packed {
		logic                put;
		put_sel_t            put_sel;
		logic [WordIdxW-1:0] sel_idx;
		logic                load;
		logic                round;
		logic [RoundW-1:0]   rnd;
		logic                add;
		logic                emit;
		logic                init;
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic full;
		logic fill_at_len;
		logic out_free;
	} status_t;

	function automatic logic [31:0] big_sigma0(input logic [31:0] x);
		return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
	endfunction

	function automatic logic [31:0] big_sigma1(input logic [31:0] x);
		return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
	endfunction

	function automatic logic [31:0] small_sigma0(input logic [31:0] x);
		return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
	endfunction

	function automatic logic [31:0] small_sigma1(input logic [31:0] x);
		return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'b0, x[31:10]};
	endfunction

endpackage

FILE: sv/shae_ctrl.sv
// controller of the sha-256 hash engine: request intake, compression
// sequencing, padding and digest emission; uses shae_pkg and assert_macros.svh
`include "assert_macros.svh"

module shae_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              msg_valid,
	input  logic              has_byte,
	input  logic              end_of_message,
	output logic              msg_stall,
	input  shae_pkg::status_t st,
	output shae_pkg::cmd_t    cmd
);

	localparam logic [shae_pkg::RoundW-1:0] RoundLast =
		shae_pkg::RoundW'(shae_pkg::Rounds - 1);
	localparam logic [shae_pkg::WordIdxW-1:0] IdxLast =
		shae_pkg::WordIdxW'(shae_pkg::HashWords - 1);

	typedef enum logic [2:0] {
		S_IDLE,
		S_LOAD,
		S_ROUND,
		S_ADD,
		S_PAD,
		S_OUT
	} state_t;

	typedef enum logic [1:0] {
		PH_MARK,
		PH_ZERO,
		PH_LEN,
		PH_DONE
	} phase_t;

	state_t                         state_q;
	phase_t                         phase_q;
	logic                           eom_q;
	logic [shae_pkg::RoundW-1:0]    rnd_q;
	logic [shae_pkg::WordIdxW-1:0]  sel_q;
	logic                           take;

	// requests are taken only while idle with room in the block
	assign msg_stall = !(state_q == S_IDLE && !st.full);
	assign take      = msg_valid && !msg_stall;

	// commands to the datapath
	always_comb begin
		cmd         = '0;
		cmd.put_sel = shae_pkg::PUT_MSG;
		cmd.rnd     = rnd_q;
		cmd.sel_idx = sel_q;
		unique case (state_q)
			S_IDLE: begin
				cmd.put = take && has_byte;
			end
			S_LOAD: begin
				cmd.load = 1'b1;
			end
			S_ROUND: begin
				cmd.round = 1'b1;
			end
			S_ADD: begin
				cmd.add = 1'b1;
			end
			S_PAD: begin
				if (!st.full) begin
					unique case (phase_q)
						PH_MARK: begin
							cmd.put     = 1'b1;
							cmd.put_sel = shae_pkg::PUT_MARK;
						end
						PH_ZERO: begin
							cmd.put     = !st.fill_at_len;
							cmd.put_sel = shae_pkg::PUT_ZERO;
						end
						PH_LEN: begin
							cmd.put     = 1'b1;
							cmd.put_sel = shae_pkg::PUT_LEN;
						end
						default: begin
						end
					endcase
				end
			end
			S_OUT: begin
				if (st.out_free) begin
					cmd.emit = 1'b1;
					cmd.init = (sel_q == IdxLast);
				end
			end
			default: begin
			end
		endcase
	end

	// state and sequencing counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			phase_q <= PH_MARK;
			eom_q   <= 1'b0;
			rnd_q   <= '0;
			sel_q   <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (st.full) begin
						state_q <= S_LOAD;
					end else if (take && end_of_message) begin
						eom_q   <= 1'b1;
						phase_q <= PH_MARK;
						sel_q   <= '0;
						state_q <= S_PAD;
					end
				end
				S_LOAD: begin
					rnd_q   <= '0;
					state_q <= S_ROUND;
				end
				S_ROUND: begin
					rnd_q <= rnd_q + 1'b1;
					if (rnd_q == RoundLast) begin
						state_q <= S_ADD;
					end
				end
				S_ADD: begin
					state_q <= eom_q ? S_PAD : S_IDLE;
				end
				S_PAD: begin
					if (st.full) begin
						state_q <= S_LOAD;
					end else begin
						unique case (phase_q)
							PH_MARK: begin
								phase_q <= PH_ZERO;
							end
							PH_ZERO: begin
								if (st.fill_at_len) begin
									phase_q <= PH_LEN;
								end
							end
							PH_LEN: begin
								sel_q <= sel_q + 1'b1;
								if (sel_q == IdxLast) begin
									phase_q <= PH_DONE;
								end
							end
							default: begin
								state_q <= S_OUT;
							end
						endcase
					end
				end
				S_OUT: begin
					if (st.out_free) begin
						sel_q <= sel_q + 1'b1;
						if (sel_q == IdxLast) begin
							eom_q   <= 1'b0;
							state_q <= S_IDLE;
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// a compression always starts from round zero
	`ASSERT_NEXT(a_round_start, state_q == S_LOAD, state_q == S_ROUND && rnd_q == '0, "round counter not cleared")
	// the last round hands over to the final add
	`ASSERT_NEXT(a_round_end, state_q == S_ROUND && rnd_q == RoundLast, state_q == S_ADD, "round sequence overrun")
	// a digest word is loaded only into a free output register
	`ASSERT_IMPLIES(a_emit_free, cmd.emit, st.out_free, "digest word overwrites pending request")

endmodule

FILE: sv/shae_dp.sv
// datapath of the sha-256 hash engine: block window and message schedule,
// working variables, hash words, counts and digest output register; uses shae_pkg
`include "assert_macros.svh"

module shae_dp (
	input  logic              clk,
	input  logic              arst_n,
	input  logic [7:0]        data_byte,
	input  shae_pkg::cmd_t    cmd,
	output shae_pkg::status_t st,
	output logic              dig_valid,
	input  logic              dig_stall,
	output shae_pkg::dig_t    dig
);

	localparam logic [shae_pkg::FillW-1:0] FillFull = shae_pkg::FillW'(shae_pkg::BlockBytes);
	localparam logic [shae_pkg::FillW-1:0] FillLen  = shae_pkg::FillW'(shae_pkg::LenBytesAt);
	localparam logic [shae_pkg::WordIdxW-1:0] IdxLast =
		shae_pkg::WordIdxW'(shae_pkg::HashWords - 1);

	logic [31:0]                h_q [shae_pkg::HashWords];
	logic [31:0]                v_q [shae_pkg::HashWords];
	logic [31:0]                w_q [16];
	logic [shae_pkg::FillW-1:0] fill_q;
	logic [shae_pkg::LenW-1:0]  len_q;
	logic                       dig_valid_q;
	shae_pkg::dig_t             dig_q;

	logic [63:0]                len_bits_sh;
	logic [7:0]                 put_byte;
	logic [31:0]                t1;
	logic [31:0]                t2;
	logic [31:0]                ch;
	logic [31:0]                maj;
	logic [31:0]                w_next;

	// length byte in big-endian order, bit length is byte count times eight
	assign len_bits_sh = {len_q, 3'b000} << {cmd.sel_idx, 3'b000};

	// byte that enters the block window
	always_comb begin
		case (cmd.put_sel)
			shae_pkg::PUT_MSG:  put_byte = data_byte;
			shae_pkg::PUT_MARK: put_byte = shae_pkg::PadMarker;
			shae_pkg::PUT_LEN:  put_byte = len_bits_sh[63:56];
			default:            put_byte = 8'h00;
		endcase
	end

	// one compression round and the next schedule word
	assign ch     = (v_q[4] & v_q[5]) ^ (~v_q[4] & v_q[6]);
	assign maj    = (v_q[0] & v_q[1]) ^ (v_q[0] & v_q[2]) ^ (v_q[1] & v_q[2]);
	assign t1     = v_q[7] + shae_pkg::big_sigma1(v_q[4]) + ch
		+ shae_pkg::RoundK[cmd.rnd] + w_q[0];
	assign t2     = shae_pkg::big_sigma0(v_q[0]) + maj;
	assign w_next = shae_pkg::small_sigma1(w_q[14]) + w_q[9]
		+ shae_pkg::small_sigma0(w_q[1]) + w_q[0];

	// status to the controller
	assign st.full        = (fill_q == FillFull);
	assign st.fill_at_len = (fill_q == FillLen);
	assign st.out_free    = !dig_valid_q || !dig_stall;

	// hash words, counts and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < shae_pkg::HashWords; i++) begin
				h_q[i] <= shae_pkg::InitHash[i];
			end
			fill_q      <= '0;
			len_q       <= '0;
			dig_valid_q <= 1'b0;
		end else begin
			if (cmd.init) begin
				for (int i = 0; i < shae_pkg::HashWords; i++) begin
					h_q[i] <= shae_pkg::InitHash[i];
				end
			end else if (cmd.add) begin
				for (int i = 0; i < shae_pkg::HashWords; i++) begin
					h_q[i] <= h_q[i] + v_q[i];
				end
			end
			if (cmd.init || cmd.load) begin
				fill_q <= '0;
			end else if (cmd.put) begin
				fill_q <= fill_q + 1'b1;
			end
			if (cmd.init) begin
				len_q <= '0;
			end else if (cmd.put && cmd.put_sel == shae_pkg::PUT_MSG) begin
				len_q <= len_q + 1'b1;
			end
			if (cmd.emit) begin
				dig_valid_q <= 1'b1;
			end else if (!dig_stall) begin
				dig_valid_q <= 1'b0;
			end
		end
	end

	// block window: byte shift on fill, word shift with schedule during rounds
	always_ff @(posedge clk) begin
		if (cmd.put) begin
			for (int i = 0; i < 15; i++) begin
				w_q[i] <= {w_q[i][23:0], w_q[i+1][31:24]};
			end
			w_q[15] <= {w_q[15][23:0], put_byte};
		end else if (cmd.round) begin
			for (int i = 0; i < 15; i++) begin
				w_q[i] <= w_q[i+1];
			end
			w_q[15] <= w_next;
		end
	end

	// working variables
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			for (int i = 0; i < shae_pkg::HashWords; i++) begin
				v_q[i] <= h_q[i];
			end
		end else if (cmd.round) begin
			v_q[0] <= t1 + t2;
			v_q[1] <= v_q[0];
			v_q[2] <= v_q[1];
			v_q[3] <= v_q[2];
			v_q[4] <= v_q[3] + t1;
			v_q[5] <= v_q[4];
			v_q[6] <= v_q[5];
			v_q[7] <= v_q[6];
		end
	end

	// digest output register
	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			dig_q.digest_word <= h_q[cmd.sel_idx];
			dig_q.word_index  <= cmd.sel_idx;
			dig_q.last_word   <= (cmd.sel_idx == IdxLast);
		end
	end

	assign dig_valid = dig_valid_q;
	assign dig       = dig_q;

	// the block window never holds more than one block
	`ASSERT_ALWAYS(a_fill_range, fill_q <= FillFull, "block fill out of range")
	// no byte is shifted in while a full block waits for compression
	`ASSERT_IMPLIES(a_no_put_full, cmd.put, fill_q != FillFull, "byte put into full block")
	// the final flag travels only with the last digest word
	`ASSERT_IMPLIES(a_last_index, dig_valid_q && dig_q.last_word, dig_q.word_index == IdxLast, "last flag on wrong word")

endmodule

FILE: sv/sha256_hash_engine_core.sv
// sha-256 engine: one message byte per request, 64 rounds at one per cycle.
// a byte is taken per cycle while idle with room in the block buffer; a full block then
// holds the message side through full detect, load, the 64 rounds and the add.
// end of message: 9 to 72 padding bytes and one or two compressions come before the first
// digest word, then eight words follow at one per cycle unstalled.
// async active-low reset: initial hash value, zero byte count, output empty.
module sha256_hash_engine_core (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           msg_valid,
	output logic           msg_stall,
	input  shae_pkg::msg_t msg,
	output logic           dig_valid,
	input  logic           dig_stall,
	output shae_pkg::dig_t dig
);

	shae_pkg::cmd_t    cmd;
	shae_pkg::status_t st;

	// sequencing
	shae_ctrl u_ctrl (
		.clk            (clk),
		.arst_n         (arst_n),
		.msg_valid      (msg_valid),
		.has_byte       (msg.has_byte),
		.end_of_message (msg.end_of_message),
		.msg_stall      (msg_stall),
		.st             (st),
		.cmd            (cmd)
	);

	// hashing datapath and output register
	shae_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.data_byte (msg.data_byte),
		.cmd       (cmd),
		.st        (st),
		.dig_valid (dig_valid),
		.dig_stall (dig_stall),
		.dig       (dig)
	);

endmodule

FILE: sim/sha256_digest_checker.sv
`timescale 1ns / 1ps
// scoreboard for the sha-256 engine: watches both channels, predicts the digest of
// every message from the accepted requests and compares the words in order
// depends on shae_pkg for the request payload types
module sha256_digest_checker (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           msg_valid,
	input  logic           msg_stall,
	input  shae_pkg::msg_t msg,
	input  logic           dig_valid,
	input  logic           dig_stall,
	input  shae_pkg::dig_t dig,
	output int             fail_count,
	output int             words_due
);

	localparam logic [7:0] PadByte   = 8'h80;
	localparam int         LenOffset = 56;

	// per-round additive constants
	localparam logic [31:0] RoundConst [64] = '{
		32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
		32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
		32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
		32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
		32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
		32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
		32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
		32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
		32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
		32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
		32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
		32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
		32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
		32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
		32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
		32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
	};

	// chaining value at the start of every message
	localparam logic [31:0] FirstHash [8] = '{
		32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
		32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
	};

	logic [31:0]    chain [8];
	logic [7:0]     blk [64];
	logic [6:0]     blk_fill;
	logic [60:0]    byte_count;
	shae_pkg::dig_t digest_q [$];
	int             fails = 0;
	int             pending = 0;

	assign fail_count = fails;
	assign words_due  = pending;

	function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
		return (x >> n) | (x << (32 - n));
	endfunction

	// one 64-round compression of the buffered block into the chaining value
	function automatic void sha_compress();
		logic [31:0] w [64];
		logic [31:0] a, b, c, d, e, f, g, h, s0, s1, t1, t2;
		for (int t = 0; t < 16; t++)
			w[t] = {blk[4*t], blk[4*t+1], blk[4*t+2], blk[4*t+3]};
		for (int t = 16; t < 64; t++) begin
			s0 = rotr(w[t-15], 7) ^ rotr(w[t-15], 18) ^ (w[t-15] >> 3);
			s1 = rotr(w[t-2], 17) ^ rotr(w[t-2], 19) ^ (w[t-2] >> 10);
			w[t] = w[t-16] + s0 + w[t-7] + s1;
		end
		a = chain[0]; b = chain[1]; c = chain[2]; d = chain[3];
		e = chain[4]; f = chain[5]; g = chain[6]; h = chain[7];
		for (int t = 0; t < 64; t++) begin
			s1 = rotr(e, 6) ^ rotr(e, 11) ^ rotr(e, 25);
			t1 = h + s1 + ((e & f) ^ (~e & g)) + RoundConst[t] + w[t];
			s0 = rotr(a, 2) ^ rotr(a, 13) ^ rotr(a, 22);
			t2 = s0 + ((a & b) ^ (a & c) ^ (b & c));
			h = g; g = f; f = e; e = d + t1;
			d = c; c = b; b = a; a = t1 + t2;
		end
		chain[0] += a; chain[1] += b; chain[2] += c; chain[3] += d;
		chain[4] += e; chain[5] += f; chain[6] += g; chain[7] += h;
	endfunction

	function automatic void absorb_byte(input logic [7:0] value);
		blk[blk_fill[5:0]] = value;
		blk_fill = blk_fill + 7'd1;
		if (blk_fill >= 7'd64) begin
			sha_compress();
			blk_fill = '0;
		end
	endfunction

	function automatic void restart_message();
		for (int k = 0; k < 8; k++)
			chain[k] = FirstHash[k];
		blk_fill   = '0;
		byte_count = '0;
	endfunction

	// absorb one request; at end of message pad, finish and queue the eight words
	function automatic void hash_request(input shae_pkg::msg_t req);
		logic [63:0]    bit_len;
		shae_pkg::dig_t word;
		if (req.has_byte) begin
			byte_count = byte_count + 61'd1;
			absorb_byte(req.data_byte);
		end
		if (req.end_of_message) begin
			bit_len = {byte_count, 3'b000};
			absorb_byte(PadByte);
			while (blk_fill != 7'(LenOffset))
				absorb_byte(8'h00);
			for (int k = 0; k < 8; k++)
				absorb_byte(bit_len[63 - 8*k -: 8]);
			for (int k = 0; k < 8; k++) begin
				word.digest_word = chain[k];
				word.word_index  = 3'(k);
				word.last_word   = (k == 7);
				digest_q.push_back(word);
			end
			restart_message();
		end
	endfunction

	// predict on accepted message requests, compare accepted digest requests
	always @(posedge clk or negedge arst_n) begin
		shae_pkg::dig_t want;
		if (!arst_n) begin
			restart_message();
			digest_q.delete();
		end else begin
			if (msg_valid && !msg_stall)
				hash_request(msg);
			if (dig_valid && !dig_stall) begin
				if (digest_q.size() == 0) begin
					$error("digest_word: none expected, actual %h", dig.digest_word);
					fails++;
				end else begin
					want = digest_q.pop_front();
					if (dig.digest_word !== want.digest_word) begin
						$error("digest_word: expected %h, actual %h",
							want.digest_word, dig.digest_word);
						fails++;
					end
					if (dig.word_index !== want.word_index) begin
						$error("word_index: expected %0d, actual %0d",
							want.word_index, dig.word_index);
						fails++;
					end
					if (dig.last_word !== want.last_word) begin
						$error("last_word: expected %b, actual %b",
							want.last_word, dig.last_word);
						fails++;
					end
				end
			end
		end
		pending = digest_q.size();
	end

	// final block is empty; words still owed at the end of the run show on words_due
	final begin
	end

endmodule

FILE: sim/tb_sha256_hash_engine_core.sv
`timescale 1ns / 1ps
// top of the sha-256 engine bench: clock, reset, message stimulus and digest-side stalls
// depends on shae_pkg, sha256_hash_engine_core and sha256_digest_checker
module tb_sha256_hash_engine_core;

	localparam int ItemTarget = 410;
	localparam int PadEdgeLen [8] = '{55, 56, 57, 63, 64, 65, 119, 120};

	logic           clk = 1'b0;
	logic           arst_n;
	logic           msg_valid;
	logic           msg_stall;
	shae_pkg::msg_t msg;
	logic           dig_valid;
	logic           dig_stall;
	shae_pkg::dig_t dig;
	int             fail_count;
	int             words_due;
	int             items_sent = 0;
	int             burst_left = 3;
	logic [7:0]     stall_phase = '0;

	sha256_hash_engine_core uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.msg_valid (msg_valid),
		.msg_stall (msg_stall),
		.msg       (msg),
		.dig_valid (dig_valid),
		.dig_stall (dig_stall),
		.dig       (dig)
	);

	sha256_digest_checker chk (
		.clk        (clk),
		.arst_n     (arst_n),
		.msg_valid  (msg_valid),
		.msg_stall  (msg_stall),
		.msg        (msg),
		.dig_valid  (dig_valid),
		.dig_stall  (dig_stall),
		.dig        (dig),
		.fail_count (fail_count),
		.words_due  (words_due)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// digest-side stalls: free flow, coin toss, fixed rhythm, light random
	always @(posedge clk) begin
		stall_phase <= stall_phase + 8'd1;
		case (stall_phase[7:6])
			2'd0: dig_stall <= 1'b0;
			2'd1: dig_stall <= ($urandom_range(0, 1) == 0);
			2'd2: dig_stall <= (stall_phase[2:0] < 3'd5);
			default: dig_stall <= ($urandom_range(0, 3) == 0);
		endcase
	end

	// one message request; gaps between bursts of random length
	task automatic send_req(input logic [7:0] value, input logic has, input logic eom);
		int gap;
		msg_valid <= 1'b1;
		msg <= '{data_byte: value, has_byte: has, end_of_message: eom};
		do @(posedge clk); while (msg_stall);
		if (has || eom)
			items_sent++;
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			gap = $urandom_range(1, 12);
			msg_valid <= 1'b0;
			repeat (gap) @(posedge clk);
			burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 150)
				: $urandom_range(0, 10);
		end
	endtask

	// hold off the sender until every digest word has come out
	task automatic wait_digest_drain();
		msg_valid <= 1'b0;
		do @(negedge clk); while (words_due != 0);
		@(posedge clk);
	endtask

	// random bytes with the occasional filler request; end flag on the last
	// byte or on a trailing empty request
	task automatic send_message(input int len);
		logic flag_on_byte;
		flag_on_byte = (len > 0) && ($urandom_range(0, 1) == 1);
		for (int k = 0; k < len; k++) begin
			if ($urandom_range(0, 9) == 0)
				send_req(8'($urandom), 1'b0, 1'b0);
			send_req(8'($urandom), 1'b1, flag_on_byte && (k == len - 1));
		end
		if (!flag_on_byte)
			send_req(8'($urandom), 1'b0, 1'b1);
	endtask

	// mostly short messages, some around the padding and block boundaries
	function automatic int pick_length();
		int sel;
		sel = $urandom_range(0, 19);
		if (sel < 10)
			return $urandom_range(0, 12);
		if (sel < 17)
			return PadEdgeLen[$urandom_range(0, 7)];
		return $urandom_range(13, 130);
	endfunction

	initial begin
		arst_n    = 1'b0;
		msg_valid = 1'b0;
		msg       = '0;
		dig_stall = 1'b0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		// empty message: digest of the empty string
		send_req(8'hff, 1'b0, 1'b1);
		wait_digest_drain();
		// filler request, then "abc" with the end flag on the last byte
		send_req(8'h00, 1'b0, 1'b0);
		send_req(8'h61, 1'b1, 1'b0);
		send_req(8'h62, 1'b1, 1'b0);
		send_req(8'h63, 1'b1, 1'b1);
		// byte extremes with a filler inside, closed by an empty request
		send_req(8'hff, 1'b1, 1'b0);
		send_req(8'h5a, 1'b0, 1'b0);
		send_req(8'h00, 1'b1, 1'b0);
		send_req(8'hff, 1'b1, 1'b0);
		send_req(8'h00, 1'b0, 1'b1);
		// single zero byte carrying the end flag
		send_req(8'h00, 1'b1, 1'b1);
		wait_digest_drain();

		// random messages
		while (items_sent < ItemTarget) begin
			send_message(pick_length());
			if ($urandom_range(0, 3) == 0)
				wait_digest_drain();
		end

		wait_digest_drain();
		repeat (300) @(posedge clk);
		if (fail_count == 0)
			$display("[sha256_hash_engine_core] OK");
		else
			$display("[sha256_hash_engine_core] ERROR");
		$finish;
	end

	// run limit
	initial begin
		#10_000_000;
		$display("[sha256_hash_engine_core] ERROR");
		$finish;
	end

endmodule
